>>> hw/rtl/rau_pkg.sv
// rau_pkg: shared widths, word types, command codes and sequencer states
// for the rational arithmetic unit; used by every file under hw/rtl
`timescale 1ns / 1ps

package rau_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int W      = OPERAND_WIDTH;
    localparam int PW     = 2 * W;          // product width
    localparam int DW     = 2 * W + 1;      // sum / gcd / divider width
    localparam int NUM_W  = 34;
    localparam int DEN_W  = 32;
    localparam int EXT_N  = (DW + 1 > NUM_W) ? DW + 1 : NUM_W;
    localparam int EXT_D  = (DW > DEN_W) ? DW : DEN_W;
    localparam int MUL_CW = $clog2(W + 1);
    localparam int DIV_CW = $clog2(DW + 1);
    localparam int GCD_KW = $clog2(DW + 1);

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_EQ  = 3'd4;
    localparam logic [2:0] CMD_RED = 3'd5;

    typedef struct packed {
        logic [2:0]          cmd;
        logic signed [W-1:0] a_num;
        logic [W-1:0]        a_den;
        logic signed [W-1:0] b_num;
        logic [W-1:0]        b_den;
    } in_t;

    typedef struct packed {
        logic signed [NUM_W-1:0] res_num;
        logic [DEN_W-1:0]        res_den;
        logic                    is_equal;
        logic                    status;
    } out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_COMB,
        ST_GCD_GO,
        ST_GCD_WAIT,
        ST_DIVN_GO,
        ST_DIVN_WAIT,
        ST_DIVD_GO,
        ST_DIVD_WAIT,
        ST_DONE
    } state_t;

endpackage

>>> hw/rtl/rau_mul.sv
// rau_mul: bit-serial shift-and-add multiplier, one multiplier bit per cycle
// depends on rau_pkg
`timescale 1ns / 1ps

module rau_mul
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [rau_pkg::W-1:0]  a,
    input  logic [rau_pkg::W-1:0]  b,
    output logic                   done,
    output logic [rau_pkg::PW-1:0] prod
);

    logic                       busy_reg;
    logic                       done_reg;
    logic [rau_pkg::MUL_CW-1:0] cnt_reg;
    logic [rau_pkg::PW-1:0]     acc_reg;
    logic [rau_pkg::PW-1:0]     mcand_reg;
    logic [rau_pkg::W-1:0]      mplier_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == rau_pkg::MUL_CW'(rau_pkg::W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= rau_pkg::PW'(a);
            mplier_reg <= b;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

>>> hw/rtl/rau_gcd.sv
// rau_gcd: binary gcd of two nonzero values, one reduction step per cycle
// depends on rau_pkg
`timescale 1ns / 1ps

module rau_gcd
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [rau_pkg::DW-1:0] x,
    input  logic [rau_pkg::DW-1:0] y,
    output logic                   done,
    output logic [rau_pkg::DW-1:0] g
);

    logic                       busy_reg;
    logic                       done_reg;
    logic [rau_pkg::DW-1:0]     x_reg;
    logic [rau_pkg::DW-1:0]     y_reg;
    logic [rau_pkg::GCD_KW-1:0] k_reg;
    logic [rau_pkg::DW-1:0]     g_reg;
    logic                       match;

    assign match = (x_reg == y_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && match)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= x;
            y_reg <= y;
            k_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (match)
            begin
                g_reg <= x_reg << k_reg;
            end
            else if (!x_reg[0] && !y_reg[0])
            begin
                // common factor of two
                x_reg <= x_reg >> 1;
                y_reg <= y_reg >> 1;
                k_reg <= k_reg + 1'b1;
            end
            else if (!x_reg[0])
            begin
                x_reg <= x_reg >> 1;
            end
            else if (!y_reg[0])
            begin
                y_reg <= y_reg >> 1;
            end
            else if (x_reg > y_reg)
            begin
                x_reg <= x_reg - y_reg;
            end
            else
            begin
                y_reg <= y_reg - x_reg;
            end
        end
    end

    assign done = done_reg;
    assign g    = g_reg;

endmodule

>>> hw/rtl/rau_div.sv
// rau_div: restoring divider, one quotient bit per cycle
// depends on rau_pkg
`timescale 1ns / 1ps

module rau_div
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [rau_pkg::DW-1:0] dividend,
    input  logic [rau_pkg::DW-1:0] divisor,
    output logic                   done,
    output logic [rau_pkg::DW-1:0] quot
);

    logic                       busy_reg;
    logic                       done_reg;
    logic [rau_pkg::DIV_CW-1:0] cnt_reg;
    logic [rau_pkg::DW-1:0]     rem_reg;
    logic [rau_pkg::DW-1:0]     quot_reg;
    logic [rau_pkg::DW-1:0]     dsr_reg;
    logic [rau_pkg::DW:0]       rem_sh;
    logic [rau_pkg::DW:0]       rem_sub;
    logic                       fits;

    assign rem_sh  = {rem_reg, quot_reg[rau_pkg::DW-1]};
    assign rem_sub = rem_sh - {1'b0, dsr_reg};
    assign fits    = (rem_sh >= {1'b0, dsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == rau_pkg::DIV_CW'(rau_pkg::DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quot_reg <= dividend;
            dsr_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? rem_sub[rau_pkg::DW-1:0] : rem_sh[rau_pkg::DW-1:0];
            quot_reg <= {quot_reg[rau_pkg::DW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

>>> hw/rtl/rational_arithmetic_unit.sv
// rational_arithmetic_unit: top level, sequencer and result register
// depends on rau_pkg, rau_mul, rau_gcd, rau_div
`timescale 1ns / 1ps

// usage
// - in_valid / in_ready / in_data carry one operand word: command, a_num/a_den,
//   b_num/b_den; out_valid / out_ready / out_data carry one result word, in order
// - the unit works on one word at a time; in_ready is high only while the
//   sequencer is idle, and the result register lets the next word in while
//   the previous result still waits for out_ready
// - accept to out_valid: an error word goes straight to the hand-off; the
//   equal test or a zero numerator stops after the multiplies (3 for add and
//   subtract, 2 for multiply, divide and equal, 0 for reduce) and the combine
//   step; full work runs the multiplies on the shared bit-serial multiplier,
//   the combine step, the gcd, a division of the numerator and then of the
//   denominator by the gcd, and the hand-off to the result register
// - a new word is taken only once the previous result has moved into the
//   result register, at the earliest in the cycle in which out_valid rises
// - reset: sequencer idle, result register empty, no word pending
// - receiver stall: a finished result waits in the sequencer until the
//   result register is free; inputs are then still held off
// - errors (zero denominator, divide by zero, unknown command) return 0/1
//   with status set
module rational_arithmetic_unit
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  rau_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output rau_pkg::out_t out_data
);

    localparam int W  = rau_pkg::W;
    localparam int PW = rau_pkg::PW;
    localparam int DW = rau_pkg::DW;

    rau_pkg::state_t state_reg;
    rau_pkg::state_t state_next;

    // latched operands
    logic [2:0]    cmd_reg;
    logic          sa_reg;
    logic          sb_reg;
    logic [W-1:0]  ma_reg;
    logic [W-1:0]  mb_reg;
    logic [W-1:0]  da_reg;
    logic [W-1:0]  db_reg;
    logic [1:0]    step_reg;
    logic [1:0]    nsteps_reg;
    logic [PW-1:0] p_reg [3];

    // reduction operands
    logic [DW-1:0] rm_reg;
    logic [DW-1:0] rd_reg;
    logic          rs_reg;
    logic [DW-1:0] qn_reg;

    // pending result
    rau_pkg::out_t res_reg;
    rau_pkg::out_t out_reg;
    logic          out_valid_reg;

    // unit hookup
    logic          mul_start;
    logic [W-1:0]  mul_a;
    logic [W-1:0]  mul_b;
    logic          mul_done;
    logic [PW-1:0] mul_prod;
    logic          gcd_start;
    logic          gcd_done;
    logic [DW-1:0] gcd_g;
    logic          div_start;
    logic [DW-1:0] div_dividend;
    logic          div_done;
    logic [DW-1:0] div_quot;

    // accept-time decode
    logic          accept;
    logic          in_err;
    logic          in_sa;
    logic          in_sb;
    logic [W-1:0]  in_ma;
    logic [W-1:0]  in_mb;

    // combine-step values
    logic [DW-1:0] c_rm;
    logic [DW-1:0] c_rd;
    logic          c_rs;
    logic          c_bs;
    logic          c_eq;
    logic [DW-1:0] c_l;
    logic [DW-1:0] c_r;

    // result shaping
    logic [rau_pkg::EXT_N-1:0] num_ext;
    logic [rau_pkg::EXT_N-1:0] num_sgn;
    logic [rau_pkg::EXT_D-1:0] den_ext;
    logic                      out_free;

    rau_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    rau_gcd u_gcd
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gcd_start),
        .x     (rm_reg),
        .y     (rd_reg),
        .done  (gcd_done),
        .g     (gcd_g)
    );

    rau_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (gcd_g),
        .done     (div_done),
        .quot     (div_quot)
    );

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // sign and magnitude of the numerators, error screen
    assign in_sa = in_data.a_num[W-1];
    assign in_sb = in_data.b_num[W-1];
    assign in_ma = in_sa ? W'(-in_data.a_num) : W'(in_data.a_num);
    assign in_mb = in_sb ? W'(-in_data.b_num) : W'(in_data.b_num);

    always_comb
    begin
        in_err = 1'b0;
        if (!(in_data.cmd inside {[rau_pkg::CMD_ADD:rau_pkg::CMD_RED]}))
        begin
            in_err = 1'b1;
        end
        if (in_data.a_den == '0)
        begin
            in_err = 1'b1;
        end
        if ((in_data.cmd != rau_pkg::CMD_RED) && (in_data.b_den == '0))
        begin
            in_err = 1'b1;
        end
        if ((in_data.cmd == rau_pkg::CMD_DIV) && (in_data.b_num == '0))
        begin
            in_err = 1'b1;
        end
    end

    // combine the products, or the reduce operand, into a signed numerator and a denominator; set the equal flag
    always_comb
    begin
        c_l  = DW'(p_reg[0]);
        c_r  = DW'(p_reg[1]);
        c_bs = (cmd_reg == rau_pkg::CMD_SUB) ? !sb_reg : sb_reg;
        c_eq = (p_reg[0] == p_reg[1]) &&
               ((sa_reg && ma_reg != '0) == (sb_reg && mb_reg != '0));
        c_rm = '0;
        c_rd = DW'(1);
        c_rs = 1'b0;
        case (cmd_reg)
            rau_pkg::CMD_ADD, rau_pkg::CMD_SUB:
            begin
                c_rd = DW'(p_reg[2]);
                if (sa_reg == c_bs)
                begin
                    c_rm = c_l + c_r;
                    c_rs = sa_reg;
                end
                else if (c_l >= c_r)
                begin
                    c_rm = c_l - c_r;
                    c_rs = sa_reg;
                end
                else
                begin
                    c_rm = c_r - c_l;
                    c_rs = c_bs;
                end
            end
            rau_pkg::CMD_MUL, rau_pkg::CMD_DIV:
            begin
                c_rm = DW'(p_reg[0]);
                c_rd = DW'(p_reg[1]);
                c_rs = sa_reg != sb_reg;
            end
            rau_pkg::CMD_RED:
            begin
                c_rm = DW'(ma_reg);
                c_rd = DW'(da_reg);
                c_rs = sa_reg;
            end
            default:
            begin
                c_rm = '0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rau_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_err)
                    begin
                        state_next = rau_pkg::ST_DONE;
                    end
                    else if (in_data.cmd == rau_pkg::CMD_RED)
                    begin
                        state_next = rau_pkg::ST_COMB;
                    end
                    else
                    begin
                        state_next = rau_pkg::ST_MUL_GO;
                    end
                end
            end
            rau_pkg::ST_MUL_GO:
            begin
                state_next = rau_pkg::ST_MUL_WAIT;
            end
            rau_pkg::ST_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = (step_reg + 1'b1 == nsteps_reg) ?
                                 rau_pkg::ST_COMB : rau_pkg::ST_MUL_GO;
                end
            end
            rau_pkg::ST_COMB:
            begin
                if (cmd_reg == rau_pkg::CMD_EQ || c_rm == '0)
                begin
                    state_next = rau_pkg::ST_DONE;
                end
                else
                begin
                    state_next = rau_pkg::ST_GCD_GO;
                end
            end
            rau_pkg::ST_GCD_GO:
            begin
                state_next = rau_pkg::ST_GCD_WAIT;
            end
            rau_pkg::ST_GCD_WAIT:
            begin
                if (gcd_done)
                begin
                    state_next = rau_pkg::ST_DIVN_GO;
                end
            end
            rau_pkg::ST_DIVN_GO:
            begin
                state_next = rau_pkg::ST_DIVN_WAIT;
            end
            rau_pkg::ST_DIVN_WAIT:
            begin
                if (div_done)
                begin
                    state_next = rau_pkg::ST_DIVD_GO;
                end
            end
            rau_pkg::ST_DIVD_GO:
            begin
                state_next = rau_pkg::ST_DIVD_WAIT;
            end
            rau_pkg::ST_DIVD_WAIT:
            begin
                if (div_done)
                begin
                    state_next = rau_pkg::ST_DONE;
                end
            end
            rau_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = rau_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rau_pkg::ST_IDLE;
            end
        endcase
    end

    // unit strobes and operand selects
    always_comb
    begin
        in_ready     = (state_reg == rau_pkg::ST_IDLE);
        mul_start    = (state_reg == rau_pkg::ST_MUL_GO);
        gcd_start    = (state_reg == rau_pkg::ST_GCD_GO);
        div_start    = (state_reg == rau_pkg::ST_DIVN_GO) ||
                       (state_reg == rau_pkg::ST_DIVD_GO);
        div_dividend = (state_reg == rau_pkg::ST_DIVD_GO) ? rd_reg : rm_reg;
        mul_a        = da_reg;
        mul_b        = db_reg;
        case (step_reg)
            2'd0:
            begin
                mul_a = ma_reg;
                mul_b = (cmd_reg == rau_pkg::CMD_MUL) ? mb_reg : db_reg;
            end
            2'd1:
            begin
                case (cmd_reg)
                    rau_pkg::CMD_MUL:
                    begin
                        mul_a = da_reg;
                        mul_b = db_reg;
                    end
                    rau_pkg::CMD_DIV:
                    begin
                        mul_a = da_reg;
                        mul_b = mb_reg;
                    end
                    default:
                    begin
                        mul_a = mb_reg;
                        mul_b = da_reg;
                    end
                endcase
            end
            default:
            begin
                mul_a = da_reg;
                mul_b = db_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rau_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == rau_pkg::ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // final sign and width shaping of the reduced fraction
    assign num_ext = rau_pkg::EXT_N'(qn_reg);
    assign num_sgn = rs_reg ? -num_ext : num_ext;
    assign den_ext = rau_pkg::EXT_D'(div_quot);

    always_ff @(posedge clk)
    begin
        case (state_reg)
            rau_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_reg    <= in_data.cmd;
                    sa_reg     <= in_sa;
                    sb_reg     <= in_sb;
                    ma_reg     <= in_ma;
                    mb_reg     <= in_mb;
                    da_reg     <= in_data.a_den;
                    db_reg     <= in_data.b_den;
                    step_reg   <= 2'd0;
                    nsteps_reg <= (in_data.cmd == rau_pkg::CMD_ADD ||
                                   in_data.cmd == rau_pkg::CMD_SUB) ? 2'd3 : 2'd2;
                    res_reg.res_num  <= '0;
                    res_reg.res_den  <= rau_pkg::DEN_W'(1);
                    res_reg.is_equal <= 1'b0;
                    res_reg.status   <= in_err;
                end
            end
            rau_pkg::ST_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    p_reg[step_reg] <= mul_prod;
                    step_reg        <= step_reg + 1'b1;
                end
            end
            rau_pkg::ST_COMB:
            begin
                rm_reg <= c_rm;
                rd_reg <= c_rd;
                rs_reg <= c_rs;
                if (cmd_reg == rau_pkg::CMD_EQ)
                begin
                    res_reg.is_equal <= c_eq;
                end
            end
            rau_pkg::ST_DIVN_WAIT:
            begin
                if (div_done)
                begin
                    qn_reg <= div_quot;
                end
            end
            rau_pkg::ST_DIVD_WAIT:
            begin
                if (div_done)
                begin
                    res_reg.res_num <= signed'(num_sgn[rau_pkg::NUM_W-1:0]);
                    res_reg.res_den <= den_ext[rau_pkg::DEN_W-1:0];
                end
            end
            rau_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_reg <= res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    // one word at a time: no new word right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("word accepted while sequencer busy");

    // an error word always carries 0/1 and no equal flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status) |->
        (out_data.res_num == '0 && out_data.res_den == rau_pkg::DEN_W'(1) &&
         !out_data.is_equal))
        else $error("error result is not 0/1");

    // the multiplier only reports while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == rau_pkg::ST_MUL_WAIT))
        else $error("multiplier finished out of sequence");

    // a valid result never has a zero denominator
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.res_den != '0))
        else $error("zero denominator in result");
`endif

endmodule

>>> dv/rational_arithmetic_unit_tb.sv
// rational_arithmetic_unit_tb: self-checking bench for the rational arithmetic unit
// drives operand words over valid/ready and compares each result word against a
// behavioral fraction calculator; depends on rau_pkg and the rtl under hw/rtl
`timescale 1ns / 1ps

module rational_arithmetic_unit_tb;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    rau_pkg::in_t  in_data;
    logic          out_valid;
    logic          out_ready;
    rau_pkg::out_t out_data;

    rational_arithmetic_unit u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    // words waiting to be sent, and result words still owed by the unit
    rau_pkg::in_t  pending_words[$];
    rau_pkg::out_t owed_results[$];
    int   n_errors;
    int   n_sent;
    int   n_checked;
    bit   hold_sender;   // when set the driver sends nothing new

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // euclid on unsigned magnitudes
    function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // expected result word for one operand word
    function automatic rau_pkg::out_t reduce_fraction(rau_pkg::in_t w);
        rau_pkg::out_t   r;
        bit              sa, sb, bs, rs;
        longint unsigned ma, mb, da, db, lhs, rhs, rm, rd, g;
        longint signed   sn;
        sa = w.a_num[rau_pkg::W-1];
        sb = w.b_num[rau_pkg::W-1];
        ma = sa ? longint'(-longint'(w.a_num)) : longint'(w.a_num);
        mb = sb ? longint'(-longint'(w.b_num)) : longint'(w.b_num);
        da = 64'(w.a_den);
        db = 64'(w.b_den);
        rs = 1'b0;
        rm = 0;
        rd = 1;
        r  = '0;
        if (w.cmd > rau_pkg::CMD_RED || da == 0 ||
            (w.cmd != rau_pkg::CMD_RED && db == 0) ||
            (w.cmd == rau_pkg::CMD_DIV && mb == 0))
        begin
            r.status = 1'b1;
        end
        else if (w.cmd == rau_pkg::CMD_EQ)
        begin
            lhs = ma * db;
            rhs = mb * da;
            r.is_equal = (lhs == rhs) && ((sa && ma != 0) == (sb && mb != 0));
        end
        else
        begin
            case (w.cmd)
                rau_pkg::CMD_ADD, rau_pkg::CMD_SUB:
                begin
                    lhs = ma * db;
                    rhs = mb * da;
                    bs  = (w.cmd == rau_pkg::CMD_SUB) ? !sb : sb;
                    if (sa == bs)
                    begin
                        rm = lhs + rhs;
                        rs = sa;
                    end
                    else if (lhs >= rhs)
                    begin
                        rm = lhs - rhs;
                        rs = sa;
                    end
                    else
                    begin
                        rm = rhs - lhs;
                        rs = bs;
                    end
                    rd = da * db;
                end
                rau_pkg::CMD_MUL:
                begin
                    rm = ma * mb;
                    rs = sa != sb;
                    rd = da * db;
                end
                rau_pkg::CMD_DIV:
                begin
                    rm = ma * db;
                    rs = sa != sb;
                    rd = da * mb;
                end
                default:
                begin
                    rm = ma;
                    rs = sa;
                    rd = da;
                end
            endcase
            if (rm == 0)
            begin
                rs = 1'b0;
                rd = 1;
            end
            else
            begin
                g  = gcd_of(rm, rd);
                rm = rm / g;
                rd = rd / g;
            end
        end
        sn = rs ? -longint'(rm) : longint'(rm);
        r.res_num = sn[rau_pkg::NUM_W-1:0];
        r.res_den = rd[rau_pkg::DEN_W-1:0];
        return r;
    endfunction

    function automatic rau_pkg::in_t make_word(logic [2:0] c, int an, int ad, int bn, int bd);
        rau_pkg::in_t w;
        w.cmd   = c;
        w.a_num = an[rau_pkg::W-1:0];
        w.a_den = ad[rau_pkg::W-1:0];
        w.b_num = bn[rau_pkg::W-1:0];
        w.b_den = bd[rau_pkg::W-1:0];
        return w;
    endfunction

    // mostly small gaps, now and then a long one
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45)
            return 0;
        else if (p < 92)
            return $urandom_range(1, 4);
        else
            return $urandom_range(20, 300);
    endfunction

    // numerators: full range, extremes, zero, or small
    function automatic int pick_num();
        int p;
        p = $urandom_range(0, 9);
        if (p < 5)
            return $urandom_range(0, 65535) - 32768;
        else if (p == 5)
            return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
        else if (p == 6)
            return 0;
        else
            return $urandom_range(0, 40) - 20;
    endfunction

    // denominators: rarely zero so errors stay a minority
    function automatic int pick_den();
        int p;
        p = $urandom_range(0, 39);
        if (p == 0)
            return 0;
        else if (p < 20)
            return $urandom_range(1, 65535);
        else if (p < 23)
            return 65535;
        else
            return $urandom_range(1, 60);
    endfunction

    // driver: at most one nonblocking write of in_valid per edge
    int tx_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            tx_gap   = 0;
        end
        else
        begin
            automatic bit busy = in_valid && !in_ready;
            if (in_valid && in_ready)
            begin
                owed_results.push_back(reduce_fraction(in_data));
                n_sent++;
                tx_gap = gap_len();
            end
            if (!busy)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() != 0 && !hold_sender)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_words.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: check accepted result words and randomize out_ready
    int rx_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_gap    = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (owed_results.size() == 0)
                begin
                    $error("result word with nothing expected: %p", out_data);
                    n_errors++;
                end
                else
                begin
                    automatic rau_pkg::out_t e = owed_results.pop_front();
                    n_checked++;
                    if (out_data.res_num !== e.res_num)
                    begin
                        $error("res_num expected %0d got %0d", e.res_num, out_data.res_num);
                        n_errors++;
                    end
                    if (out_data.res_den !== e.res_den)
                    begin
                        $error("res_den expected %0d got %0d", e.res_den, out_data.res_den);
                        n_errors++;
                    end
                    if (out_data.is_equal !== e.is_equal)
                    begin
                        $error("is_equal expected %0b got %0b",
                               e.is_equal, out_data.is_equal);
                        n_errors++;
                    end
                    if (out_data.status !== e.status)
                    begin
                        $error("status expected %0b got %0b", e.status, out_data.status);
                        n_errors++;
                    end
                end
                rx_gap = gap_len();
            end
            if (rx_gap > 0)
            begin
                rx_gap--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // stimulus and end of run
    initial
    begin
        rau_pkg::in_t w;
        int           c;
        n_errors    = 0;
        n_sent      = 0;
        n_checked   = 0;
        hold_sender = 1'b0;
        rst_n       = 1'b0;

        // directed: each command, extremes, zero numerators, error cases
        pending_words.push_back(make_word(rau_pkg::CMD_ADD, 1, 2, 1, 3));
        pending_words.push_back(make_word(rau_pkg::CMD_SUB, 1, 2, 1, 2));
        pending_words.push_back(make_word(rau_pkg::CMD_SUB, -32768, 1, 32767, 65535));
        pending_words.push_back(make_word(rau_pkg::CMD_ADD, -32768, 65535, -32768, 65535));
        pending_words.push_back(make_word(rau_pkg::CMD_ADD, 32767, 1, 32767, 1));
        pending_words.push_back(make_word(rau_pkg::CMD_MUL, -32768, 65535, -32768, 65535));
        pending_words.push_back(make_word(rau_pkg::CMD_MUL, 32767, 1, -32768, 1));
        pending_words.push_back(make_word(rau_pkg::CMD_MUL, 0, 7, 5, 3));
        pending_words.push_back(make_word(rau_pkg::CMD_DIV, 3, 4, -6, 8));
        pending_words.push_back(make_word(rau_pkg::CMD_DIV, -32768, 65535, 1, 65535));
        pending_words.push_back(make_word(rau_pkg::CMD_DIV, 5, 7, 0, 3));
        pending_words.push_back(make_word(rau_pkg::CMD_EQ, 2, 4, 1, 2));
        pending_words.push_back(make_word(rau_pkg::CMD_EQ, -2, 4, 1, 2));
        pending_words.push_back(make_word(rau_pkg::CMD_EQ, 0, 4, 0, 9));
        pending_words.push_back(make_word(rau_pkg::CMD_EQ, 1, 3, 1, 4));
        pending_words.push_back(make_word(rau_pkg::CMD_RED, -12, 18, 0, 0));
        pending_words.push_back(make_word(rau_pkg::CMD_RED, 0, 65535, 5, 0));
        pending_words.push_back(make_word(rau_pkg::CMD_RED, 5, 0, 1, 1));
        pending_words.push_back(make_word(rau_pkg::CMD_ADD, 1, 2, 1, 0));
        pending_words.push_back(make_word(3'd6, 1, 2, 1, 3));
        pending_words.push_back(make_word(3'd7, -1, 65535, -1, 65535));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // hold the sender off until the directed words have all come back
        wait (pending_words.size() == 0);
        hold_sender = 1'b1;
        wait (owed_results.size() == 0 && !in_valid);
        hold_sender = 1'b0;

        // random words; mostly valid commands, a few unknown ones
        for (int i = 0; i < 1630; i++)
        begin
            c = $urandom_range(0, 49);
            w.cmd   = (c < 48) ? 3'(c % 6) : 3'(6 + (c & 1));
            w.a_num = rau_pkg::W'(pick_num());
            w.a_den = rau_pkg::W'(pick_den());
            w.b_num = rau_pkg::W'(pick_num());
            w.b_den = rau_pkg::W'(pick_den());
            if (w.cmd == rau_pkg::CMD_EQ && $urandom_range(0, 2) == 0)
            begin
                // equal pairs by scaling
                c = $urandom_range(1, 8);
                w.a_num = rau_pkg::W'($urandom_range(0, 4000) - 2000);
                w.a_den = rau_pkg::W'($urandom_range(1, 8000));
                w.b_num = rau_pkg::W'(w.a_num * c);
                w.b_den = rau_pkg::W'(w.a_den * c);
            end
            pending_words.push_back(w);
            if (i == 800)
            begin
                wait (pending_words.size() == 0);
                hold_sender = 1'b1;
                wait (owed_results.size() == 0 && !in_valid);
                hold_sender = 1'b0;
            end
        end

        wait (pending_words.size() == 0 && !in_valid);
        wait (owed_results.size() == 0);
        repeat (200) @(posedge clk);

        $display("sent %0d operand words over all six commands, unknown commands",
                 n_sent);
        $display("and zero denominators, checked %0d results", n_checked);
        if (n_errors == 0 && owed_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog: worst case for ~1650 words, each with its busy, stall and gap time,
    // at 20 ns a clock is about 27 ms
    initial
    begin
        #150ms;
        $display("timeout after %0d results", n_checked);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
